// ===== rtl/rwff_pkg.sv =====
package rwff_pkg;

   // item kinds
   localparam logic [1:0] KIND_FRAME = 2'd0;
   localparam logic [1:0] KIND_OPEN  = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;

   // verdict codes
   localparam logic [1:0] VERDICT_OK     = 2'd0;
   localparam logic [1:0] VERDICT_DENIED = 2'd1;
   localparam logic [1:0] VERDICT_REPLAY = 2'd2;
   localparam logic [1:0] VERDICT_BADMSG = 2'd3;

   // legal total frame length, and payload size offset
   localparam logic [7:0] LEN_MIN = 8'd31;
   localparam logic [7:0] LEN_MAX = 8'd244;

   localparam logic [7:0] RESULT_EXTRA = 8'd2;

   localparam int COUNTER_W = 64;
   localparam int HIGHEST_W = 63;

   typedef struct packed {
      logic [1:0]           kind;
      logic [COUNTER_W-1:0] counter;
      logic [7:0]           frame_length;
      logic [7:0]           length_byte;
      logic                 id_match;
      logic                 mac_ok;
   } req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [7:0] result_length;
   } rsp_type;

   // window control state; the bitmap travels separately (width follows a parameter)
   typedef struct packed {
      logic                 session_open;
      logic                 any_seen;
      logic [HIGHEST_W-1:0] highest;
   } win_state_type;

endpackage

// ===== rtl/rwff_check.sv =====
module rwff_check #(
   parameter int WINDOW_SIZE = 32
) (
   input  rwff_pkg::req_type       item,
   input  rwff_pkg::win_state_type st,
   input  logic [WINDOW_SIZE-1:0]  window,
   output rwff_pkg::rsp_type       result,
   output rwff_pkg::win_state_type st_nxt,
   output logic [WINDOW_SIZE-1:0]  window_nxt
);
   import rwff_pkg::*;

   localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

   logic [HIGHEST_W-1:0]   cnt;
   logic [HIGHEST_W-1:0]   behind;
   logic [HIGHEST_W-1:0]   ahead;
   logic                   not_ahead;
   logic                   behind_far;
   logic                   ahead_far;
   logic [IDX_W-1:0]       bidx;
   logic [IDX_W-1:0]       aidx;
   logic                   denied;
   logic                   replay;
   logic                   bad_msg;
   logic                   bit_seen;
   logic [WINDOW_SIZE-1:0] win_shift;
   logic [WINDOW_SIZE-1:0] win_mark;

   assign cnt        = item.counter[HIGHEST_W-1:0];
   assign not_ahead  = (cnt <= st.highest);
   assign behind     = st.highest - cnt;
   assign ahead      = cnt - st.highest;
   assign behind_far = (behind >= HIGHEST_W'(WINDOW_SIZE));
   assign ahead_far  = (ahead >= HIGHEST_W'(WINDOW_SIZE));
   assign bidx       = behind[IDX_W-1:0];
   assign aidx       = ahead[IDX_W-1:0];

   assign bit_seen = behind_far ? 1'b1 : window[bidx];

   assign denied = !st.session_open || (item.frame_length < LEN_MIN)
                   || (item.frame_length > LEN_MAX) || !item.id_match
                   || item.counter[COUNTER_W-1];
   assign replay  = st.any_seen && not_ahead && bit_seen;
   assign bad_msg = !item.mac_ok || (item.length_byte != (item.frame_length - LEN_MIN));

   // window moves forward, or marks an older counter
   assign win_shift = (window << aidx) | WINDOW_SIZE'(1);
   assign win_mark  = window | (WINDOW_SIZE'(1) << bidx);

   always_comb begin
      st_nxt               = st;
      window_nxt           = window;
      result.verdict       = VERDICT_OK;
      result.result_length = '0;
      case (item.kind)
         KIND_FRAME: begin
            if (denied) begin
               result.verdict = VERDICT_DENIED;
            end else if (replay) begin
               result.verdict = VERDICT_REPLAY;
            end else if (bad_msg) begin
               result.verdict = VERDICT_BADMSG;
            end else begin
               result.result_length = item.length_byte + RESULT_EXTRA;
               st_nxt.any_seen      = 1'b1;
               if (!st.any_seen || !not_ahead) begin
                  st_nxt.highest = cnt;
                  window_nxt     = (!st.any_seen || ahead_far) ? WINDOW_SIZE'(1) : win_shift;
               end else begin
                  window_nxt = win_mark;
               end
            end
         end
         KIND_OPEN: begin
            st_nxt.session_open = 1'b1;
            st_nxt.any_seen     = 1'b0;
            st_nxt.highest      = '0;
            window_nxt          = '0;
         end
         KIND_CLOSE: begin
            st_nxt     = '0;
            window_nxt = '0;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/replay_window_frame_filter.sv =====
// Channel  | Ports                          | Direction | Moves
// ---------+--------------------------------+-----------+------------------------------
// request  | req_valid, req_ready, req_data | in        | one frame check or session op
// response | rsp_valid, rsp_ready, rsp_data | out       | verdict and result length
//
// One transfer accepted per cycle while the response side drains; a response passes through
// the input register, then the result register, and transfers from the result register.
// The window check and update for one item fits between the input and result registers.
// Synchronous active-high reset clears both valid flags, the session and the window.
// With rsp_ready low the result holds; req_ready drops only once the input register
// is full as well.
module replay_window_frame_filter #(
   parameter int WINDOW_SIZE = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rwff_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rwff_pkg::rsp_type rsp_data
);
   import rwff_pkg::*;

   // input register stage
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;

   // result register stage
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;

   // window state
   win_state_type          st_ff;
   win_state_type          st_in;
   logic [WINDOW_SIZE-1:0] window_ff;
   logic [WINDOW_SIZE-1:0] window_in;

   // check results
   rsp_type                chk_rsp;
   win_state_type          chk_st;
   logic [WINDOW_SIZE-1:0] chk_window;

   logic advance;
   logic take;

   // item in the input register moves to the result register when that is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   rwff_check #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_check (
      .item       (in_data_ff),
      .st         (st_ff),
      .window     (window_ff),
      .result     (chk_rsp),
      .st_nxt     (chk_st),
      .window_nxt (chk_window)
   );

   // state commits only as the item leaves the input register
   assign st_in     = advance ? chk_st : st_ff;
   assign window_in = advance ? chk_window : window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '0;
         window_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff        <= st_in;
         window_ff    <= window_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= chk_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // newest accepted counter always has its own bit
   a_bit0_set: assert property (@(posedge clock) disable iff (reset)
      st_ff.any_seen |-> window_ff[0])
      else $error("window bit 0 clear while a frame has been seen");

   a_empty_window: assert property (@(posedge clock) disable iff (reset)
      !st_ff.any_seen |-> (window_ff == '0) && (st_ff.highest == '0))
      else $error("window not empty before first accepted frame");

   a_seen_needs_session: assert property (@(posedge clock) disable iff (reset)
      st_ff.any_seen |-> st_ff.session_open)
      else $error("frames seen without an open session");

   a_highest_monotonic: assert property (@(posedge clock) disable iff (reset)
      (st_ff.any_seen && $past(st_ff.any_seen)) |-> (st_ff.highest >= $past(st_ff.highest)))
      else $error("highest counter moved back");

   a_reject_no_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.verdict != VERDICT_OK)) |-> (rsp_data_ff.result_length == '0))
      else $error("rejected frame carries a length");

endmodule
